// File: sv/mpl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl_pkg
// Shared types and constants of the 2x2 max pooling line buffer.
// ============================================================================
package mpl_pkg;

    localparam int NUM_FIELDS = 4;
    localparam int FIELD_W    = 16;
    localparam int ADDR_W_MAX = 10;
    localparam int ROW_W      = 10;
    localparam int WID_W      = 7;
    localparam int HGT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [HGT_W-1:0] ROW_LIMIT       = 11'd1024;
    localparam logic [WID_W-1:0] TILE_WIDTH_RST  = 7'd64;
    localparam logic [HGT_W-1:0] TILE_HEIGHT_RST = 11'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_ENABLE = 2'd0,
        CFG_TILE_WIDTH  = 2'd1,
        CFG_TILE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_POOL  = 2'd1,
        OP_PASS  = 2'd2
    } t_op;

    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        t_op                             op;
        logic [ADDR_W_MAX-1:0]           addr;
        t_field [NUM_FIELDS-1:0]         pix;
        t_field [NUM_FIELDS-1:0]         left;
    } t_cmd;

endpackage

// File: sv/mpl_ifs.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl interfaces
// Pixel request, pooled result and register write channels.
// ============================================================================
interface mpl_pix_if;
    logic                                valid;
    logic                                ready;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_in_0;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_in_1;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_in_2;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_in_3;

    modport source (output valid, output lane_in_0, output lane_in_1,
                    output lane_in_2, output lane_in_3, input ready);
    modport sink   (input valid, input lane_in_0, input lane_in_1,
                    input lane_in_2, input lane_in_3, output ready);
endinterface

interface mpl_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_out_0;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_out_1;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_out_2;
    logic signed [mpl_pkg::FIELD_W-1:0]  lane_out_3;

    modport source (output valid, output lane_out_0, output lane_out_1,
                    output lane_out_2, output lane_out_3, input ready);
    modport sink   (input valid, input lane_out_0, input lane_out_1,
                    input lane_out_2, input lane_out_3, output ready);
endinterface

interface mpl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mpl_pkg::CFG_IDX_W-1:0]       index;
    logic [mpl_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mpl_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl_ram
// Generic RAM, one write port and two registered read ports.
// ============================================================================
module mpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr_b,
    output logic [WIDTH-1:0]           o_rd_data_a,
    output logic [WIDTH-1:0]           o_rd_data_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;
endmodule

// File: sv/mpl_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl_front
// Register file, tile position counters and request classification.
// ============================================================================
module mpl_front #(
    parameter int LANES          = 4,
    parameter int LANE_WIDTH     = 16,
    parameter int MAX_TILE_WIDTH = 64
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  mpl_pkg::t_field [mpl_pkg::NUM_FIELDS-1:0]       i_pix,
    output logic                                            o_ready,
    input  logic                                            i_cfg_valid,
    input  logic [mpl_pkg::CFG_IDX_W-1:0]                   i_cfg_index,
    input  logic [mpl_pkg::CFG_DATA_W-1:0]                  i_cfg_data,
    output logic                                            o_cfg_ready,
    output logic                                            o_cmd_valid,
    output mpl_pkg::t_cmd                                   o_cmd,
    input  logic                                            i_cmd_ready
);
    import mpl_pkg::*;

    localparam int COL_W = $clog2(MAX_TILE_WIDTH);
    localparam int BND_W = $clog2(MAX_TILE_WIDTH + 1);
    localparam int CMP_W = (BND_W > WID_W) ? BND_W : WID_W;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_TILE_WIDTH);

    logic                                  r_pool_en;
    logic [WID_W-1:0]                      r_tile_width;
    logic [HGT_W-1:0]                      r_tile_height;
    logic [COL_W-1:0]                      r_col, n_col;
    logic [ROW_W-1:0]                      r_row, n_row;
    logic [LANES-1:0][LANE_WIDTH-1:0]      r_left;

    logic [CMP_W-1:0]  w_bound;
    logic [CMP_W-1:0]  col_inc;
    logic [HGT_W-1:0]  h_bound;
    logic [HGT_W-1:0]  row_inc;
    logic              take;
    logic              step;
    t_op               cmd_op;

    // register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_en     <= 1'b0;
            r_tile_width  <= TILE_WIDTH_RST;
            r_tile_height <= TILE_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POOL_ENABLE: r_pool_en     <= i_cfg_data[0];
                CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_data[WID_W-1:0];
                CFG_TILE_HEIGHT: r_tile_height <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // tile position
    assign w_bound = (r_tile_width == '0 || CMP_W'(r_tile_width) > MAX_W)
                     ? MAX_W : CMP_W'(r_tile_width);
    assign col_inc = CMP_W'(r_col) + CMP_W'(1);
    assign h_bound = (r_tile_height == '0 || r_tile_height > ROW_LIMIT)
                     ? ROW_LIMIT : r_tile_height;
    assign row_inc = HGT_W'(r_row) + HGT_W'(1);

    assign take = i_valid && i_cmd_ready;
    assign step = take && r_pool_en;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (step) begin
            if (col_inc >= w_bound) begin
                n_col = '0;
                n_row = (row_inc >= h_bound) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (step && !r_col[0]) begin
                for (int k = 0; k < LANES; k++) begin
                    r_left[k] <= i_pix[k][LANE_WIDTH-1:0];
                end
            end
        end
    end

    // classification
    always_comb begin
        cmd_op      = OP_PASS;
        o_cmd_valid = 1'b0;
        if (!r_pool_en) begin
            cmd_op      = OP_PASS;
            o_cmd_valid = i_valid;
        end else if (!r_row[0]) begin
            cmd_op      = OP_STORE;
            o_cmd_valid = i_valid;
        end else if (r_col[0]) begin
            cmd_op      = OP_POOL;
            o_cmd_valid = i_valid;
        end
    end

    assign o_ready    = i_cmd_ready;
    assign o_cmd.op   = cmd_op;
    assign o_cmd.addr = ADDR_W_MAX'(r_col);
    assign o_cmd.pix  = i_pix;

    for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_left
        if (k < LANES) begin : g_on
            assign o_cmd.left[k] = FIELD_W'(r_left[k]);
        end else begin : g_off
            assign o_cmd.left[k] = '0;
        end
    end
endmodule

// File: sv/mpl_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl_fifo
// Short request queue between the front and the back.
// ============================================================================
module mpl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mpl_pkg::t_cmd  i_data,
    output logic           o_ready,
    output logic           o_valid,
    output mpl_pkg::t_cmd  o_data,
    input  logic           i_ready
);
    import mpl_pkg::*;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end
endmodule

// File: sv/mpl_back.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl_back
// Row store access, lane-wise window maximum and result register.
// ============================================================================
module mpl_back #(
    parameter int LANES          = 4,
    parameter int LANE_WIDTH     = 16,
    parameter int MAX_TILE_WIDTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cmd_valid,
    input  mpl_pkg::t_cmd                               i_cmd,
    output logic                                        o_cmd_ready,
    output logic                                        o_valid,
    output mpl_pkg::t_field [mpl_pkg::NUM_FIELDS-1:0]   o_lane,
    input  logic                                        i_ready
);
    import mpl_pkg::*;

    localparam int COL_W = $clog2(MAX_TILE_WIDTH);
    localparam int ROW_BITS = LANES * LANE_WIDTH;

    logic                                  head_store;
    logic                                  b_free;
    logic                                  out_load;
    logic                                  pop;
    logic [COL_W-1:0]                      col;
    logic [LANES-1:0][LANE_WIDTH-1:0]      wr_lanes;
    logic [LANES-1:0][LANE_WIDTH-1:0]      rd_ul;
    logic [LANES-1:0][LANE_WIDTH-1:0]      rd_ur;
    t_field [NUM_FIELDS-1:0]               max_lane;

    logic                                  r_b_valid;
    t_op                                   r_b_op;
    t_field [NUM_FIELDS-1:0]               r_b_pix;
    logic [LANES-1:0][LANE_WIDTH-1:0]      r_b_left;
    logic                                  r_o_valid;
    t_field [NUM_FIELDS-1:0]               r_o_lane;

    assign head_store  = (i_cmd.op == OP_STORE);
    assign out_load    = r_b_valid && (!r_o_valid || i_ready);
    assign b_free      = !r_b_valid || out_load;
    assign o_cmd_ready = head_store || b_free;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign col         = i_cmd.addr[COL_W-1:0];

    for (genvar k = 0; k < LANES; k++) begin : g_wr
        assign wr_lanes[k] = i_cmd.pix[k][LANE_WIDTH-1:0];
    end

    // upper left sits at the even column below the odd one
    mpl_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_TILE_WIDTH)
    ) u_row_store (
        .i_clk       (i_clk),
        .i_wr_en     (pop && head_store),
        .i_wr_addr   (col),
        .i_wr_data   (wr_lanes),
        .i_rd_en     (pop && (i_cmd.op == OP_POOL)),
        .i_rd_addr_a (col & ~COL_W'(1)),
        .i_rd_addr_b (col),
        .o_rd_data_a (rd_ul),
        .o_rd_data_b (rd_ur)
    );

    always_ff @(posedge i_clk) begin
        if (pop && !head_store) begin
            r_b_op  <= i_cmd.op;
            r_b_pix <= i_cmd.pix;
            for (int k = 0; k < LANES; k++) begin
                r_b_left[k] <= i_cmd.left[k][LANE_WIDTH-1:0];
            end
        end
        if (out_load) begin
            r_o_lane <= (r_b_op == OP_POOL) ? max_lane : r_b_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop && !head_store) begin
                r_b_valid <= 1'b1;
            end else if (out_load) begin
                r_b_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // lane-wise max of the 2x2 window
    for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
        if (k < LANES) begin : g_on
            logic signed [LANE_WIDTH-1:0] s_ul, s_ur, s_l, s_p, s_top, s_bot, s_max;
            assign s_ul  = $signed(rd_ul[k]);
            assign s_ur  = $signed(rd_ur[k]);
            assign s_l   = $signed(r_b_left[k]);
            assign s_p   = $signed(r_b_pix[k][LANE_WIDTH-1:0]);
            assign s_top = (s_ul > s_ur) ? s_ul : s_ur;
            assign s_bot = (s_l > s_p) ? s_l : s_p;
            assign s_max = (s_top > s_bot) ? s_top : s_bot;
            assign max_lane[k] = FIELD_W'(s_max);
        end else begin : g_off
            assign max_lane[k] = '0;
        end
    end

    assign o_valid = r_o_valid;
    assign o_lane  = r_o_lane;
endmodule

// File: sv/max_pool_2x2_line_buffer.sv
`timescale 1ns / 1ps
// ============================================================================
// max_pool_2x2_line_buffer
// 2x2 stride-2 max pooling over a raster-order tile, with a bypass mode.
// ============================================================================
// One pixel request is taken every clock cycle while the result side keeps up.
// The front keeps the column and row position and the held left pixel and
// sorts each request into a row-store write, a window maximum, a pass-through
// or, at an even column of an odd row, a left pixel that is only held; a
// two-entry queue hands the others to the back, whose row store has one
// write port and two registered read ports. The row store needs no clearing
// after reset. The user must write registers only while nothing is in flight
// (the block does not enforce it); a write does not reset the tile position.
module max_pool_2x2_line_buffer #(
    parameter int LANES          = 4,
    parameter int LANE_WIDTH     = 16,
    parameter int MAX_TILE_WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpl_pix_if.sink      i_pix,
    mpl_res_if.source    o_pool,
    mpl_cfg_if.sink      i_cfg
);
    import mpl_pkg::*;

    t_field [NUM_FIELDS-1:0]  pix_fields;
    t_field [NUM_FIELDS-1:0]  res_fields;
    t_cmd                     front_cmd;
    logic                     front_valid;
    logic                     front_ready;
    t_cmd                     back_cmd;
    logic                     back_valid;
    logic                     back_ready;

    assign pix_fields[0] = i_pix.lane_in_0;
    assign pix_fields[1] = i_pix.lane_in_1;
    assign pix_fields[2] = i_pix.lane_in_2;
    assign pix_fields[3] = i_pix.lane_in_3;

    mpl_front #(
        .LANES          (LANES),
        .LANE_WIDTH     (LANE_WIDTH),
        .MAX_TILE_WIDTH (MAX_TILE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pix.valid),
        .i_pix       (pix_fields),
        .o_ready     (i_pix.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    mpl_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_cmd),
        .o_ready (front_ready),
        .o_valid (back_valid),
        .o_data  (back_cmd),
        .i_ready (back_ready)
    );

    mpl_back #(
        .LANES          (LANES),
        .LANE_WIDTH     (LANE_WIDTH),
        .MAX_TILE_WIDTH (MAX_TILE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .i_cmd       (back_cmd),
        .o_cmd_ready (back_ready),
        .o_valid     (o_pool.valid),
        .o_lane      (res_fields),
        .i_ready     (o_pool.ready)
    );

    assign o_pool.lane_out_0 = res_fields[0];
    assign o_pool.lane_out_1 = res_fields[1];
    assign o_pool.lane_out_2 = res_fields[2];
    assign o_pool.lane_out_3 = res_fields[3];
endmodule

// File: sv/mpl_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// mpl_chk
// Port-level checks of the max pooling line buffer.
// ============================================================================
module mpl_chk (
    input logic                                         i_clk,
    input logic                                         i_rst_n,
    input logic                                         i_in_ready,
    input logic                                         i_out_valid,
    input logic                                         i_out_ready,
    input logic [mpl_pkg::NUM_FIELDS*mpl_pkg::FIELD_W-1:0] i_out_data
);
    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("stalled result changed");

    // queue cannot fill while the result side drains
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_ready) |-> i_in_ready)
        else $error("request side stalled although the result side was ready");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");
endmodule

bind max_pool_2x2_line_buffer mpl_chk u_mpl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pool.valid),
    .i_out_ready (o_pool.ready),
    .i_out_data  ({o_pool.lane_out_3, o_pool.lane_out_2,
                   o_pool.lane_out_1, o_pool.lane_out_0})
);
